>>> design/mts_pkg.sv
// ============================================================================
// mts_pkg
// Shared types, codes and helpers for the mipmap texture sampler.
// ============================================================================
`default_nettype none

package mts_pkg;

  // default sizing
  localparam int MAX_DIM_LOG2_DEF = 8;
  localparam int MAX_LEVELS_DEF   = 9;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int TIDX_W    = 16;
  localparam int RGBA_W    = 32;
  localparam int COORD_W   = 17;
  localparam int LVL_W     = 4;
  localparam int FRAC_W    = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;

  // request kinds
  localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEAREST  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BILINEAR = 2'd3;

  // configuration register indexes
  localparam logic REG_BASE_WIDTH  = 1'b0;
  localparam logic REG_BASE_HEIGHT = 1'b1;

  // rounding half of a q.16 position
  localparam logic [FRAC_W:0] HALF_Q16 = 17'h08000;
  localparam logic [FRAC_W:0] ONE_Q16  = 17'h10000;

  typedef logic [LVL_W-1:0] lvl_t;

  // floor(log2(d)) + 1 for d >= 1
  function automatic lvl_t level_span(input logic [15:0] d);
    lvl_t n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      if (d[i]) n = lvl_t'(i + 1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/mts_ram.sv
// ============================================================================
// mts_ram
// Generic single-clock RAM, one write port and one registered read port.
// ============================================================================
`default_nettype none

module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/mts_lerp.sv
// ============================================================================
// mts_lerp
// Bilinear blend of four RGBA8 texels, one channel at a time.
// ============================================================================
`default_nettype none

module mts_lerp
  import mts_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire [RGBA_W-1:0]    tex_a,
  input  wire [RGBA_W-1:0]    tex_b,
  input  wire [RGBA_W-1:0]    tex_d,
  input  wire [RGBA_W-1:0]    tex_e,
  input  wire [FRAC_W-1:0]    frac_x,
  input  wire [FRAC_W-1:0]    frac_y,
  output logic                done,
  output logic [RGBA_W-1:0]   color
);

  logic        run_r;
  logic        phase_r;
  logic [1:0]  ch_r;
  logic [24:0] r1_r, r2_r;
  logic [RGBA_W-1:0] color_r;
  logic        done_r;

  logic [7:0]  ca, cb, cd, ce;
  logic [16:0] wx0, wx1, wy0, wy1;
  logic [24:0] r1_nxt, r2_nxt;
  logic [42:0] r_sum;
  logic [10:0] q;
  logic [7:0]  q_sat;

  // channel select and weights
  always_comb begin
    ca  = tex_a[8*ch_r +: 8];
    cb  = tex_b[8*ch_r +: 8];
    cd  = tex_d[8*ch_r +: 8];
    ce  = tex_e[8*ch_r +: 8];
    wx1 = {1'b0, frac_x};
    wx0 = ONE_Q16 - wx1;
    wy1 = {1'b0, frac_y};
    wy0 = ONE_Q16 - wy1;
    r1_nxt = 25'(ca * wx0) + 25'(cb * wx1);
    r2_nxt = 25'(cd * wx0) + 25'(ce * wx1);
    r_sum  = 43'(r1_r * wy0) + 43'(r2_r * wy1) + 43'h0_8000_0000;
    q      = r_sum[42:32];
    q_sat  = (q > 11'd255) ? 8'hFF : q[7:0];
  end

  // channel sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      phase_r <= 1'b0;
      ch_r    <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r   <= 1'b1;
        phase_r <= 1'b0;
        ch_r    <= 2'd0;
      end else if (run_r) begin
        phase_r <= ~phase_r;
        if (phase_r) begin
          ch_r <= ch_r + 2'd1;
          if (ch_r == 2'd3) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  // horizontal then vertical blend
  always_ff @(posedge clk) begin
    if (run_r && !phase_r) begin
      r1_r <= r1_nxt;
      r2_r <= r2_nxt;
    end
    if (run_r && phase_r) color_r[8*ch_r +: 8] <= q_sat;
  end

  assign done  = done_r;
  assign color = color_r;

endmodule

`default_nettype wire

>>> design/mipmap_texture_sampler.sv
// ============================================================================
// mipmap_texture_sampler
// Texel store with box-filter mip build and nearest or bilinear sampling.
// ============================================================================
// One request at a time. A base texel write passes through the done state; a
// nearest sample makes one read, a bilinear sample four reads of the single
// texel read port and then a channel-by-channel pass of the blend unit. A
// mip build makes four reads and one write of the texel memory per mip texel
// and a setup step per mip level. A result can wait on the output
// register while the next request is taken. Writing base_width or base_height
// drops the mip chain.
`default_nettype none

module mipmap_texture_sampler
  import mts_pkg::*;
#(
  parameter int MAX_DIM_LOG2 = MAX_DIM_LOG2_DEF,
  parameter int MAX_LEVELS   = MAX_LEVELS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // texel_index, texel_rgba, coord_u, coord_v, mip_level (low bit up)
  input  wire [IN_DATA_W-1:0]          in_tdata,
  // cmd
  input  wire [CMD_W-1:0]              in_tuser,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // color_rgba, levels_in_use (low bit up)
  output logic [OUT_DATA_W-1:0]        out_tdata,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  input  wire                          cfg_we,
  input  wire                          cfg_index,
  input  wire [MAX_DIM_LOG2:0]         cfg_data
);

  localparam int DIM_W  = MAX_DIM_LOG2 + 1;
  localparam int CRD_W  = MAX_DIM_LOG2;
  localparam int SX_W   = DIM_W + 1;
  localparam int POS_W  = DIM_W + COORD_W;
  localparam int DEPTH  = ((1 << (2 * (MAX_DIM_LOG2 + 1))) - 1) / 3;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LIDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int CMP_W  = (2 * DIM_W > TIDX_W) ? 2 * DIM_W : TIDX_W;
  localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(1) << MAX_DIM_LOG2;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BLV  = 4'd1;
  localparam logic [3:0] ST_BRD  = 4'd2;
  localparam logic [3:0] ST_BWR  = 4'd3;
  localparam logic [3:0] ST_SPOS = 4'd4;
  localparam logic [3:0] ST_SRD  = 4'd5;
  localparam logic [3:0] ST_SWT  = 4'd6;
  localparam logic [3:0] ST_LERP = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  // input unpacking
  logic [TIDX_W-1:0]  f_tidx;
  logic [RGBA_W-1:0]  f_rgba;
  logic [COORD_W-1:0] f_u, f_v;
  logic [LVL_W-1:0]   f_lvl;
  assign f_tidx = in_tdata[15:0];
  assign f_rgba = in_tdata[47:16];
  assign f_u    = in_tdata[64:48];
  assign f_v    = in_tdata[81:65];
  assign f_lvl  = in_tdata[85:82];

  logic [3:0]         state_r;
  logic [DIM_W-1:0]   wreg_r, hreg_r;
  lvl_t               level_count_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [COORD_W-1:0] u_r, v_r;
  logic [LIDX_W-1:0]  lv_r;
  logic               lv0_r;
  logic [1:0]         q_r;
  logic               rd_pend_r;
  logic [1:0]         rd_slot_r;
  logic [RGBA_W-1:0]  tex_r [4];

  // per-level geometry
  logic [DIM_W-1:0]   lw_r [MAX_LEVELS];
  logic [DIM_W-1:0]   lh_r [MAX_LEVELS];
  logic [ADDR_W-1:0]  lb_r [MAX_LEVELS];

  // build sequencer
  lvl_t               n_r;
  logic [LIDX_W-1:0]  lvl_r;
  logic [DIM_W-1:0]   pw_r, ph_r, cw_r, ch_r;
  logic [ADDR_W-1:0]  pb_r, dst_r;
  logic [CRD_W-1:0]   bx_r, by_r;

  // sample setup
  logic [DIM_W-1:0]   sw_r, sh_r;
  logic [ADDR_W-1:0]  sb_r;
  logic [POS_W-1:0]   px_r, py_r;

  logic               in_fire;
  logic [DIM_W-1:0]   w0, h0;
  logic [DIM_W-1:0]   mx;
  lvl_t               n_span, n_cap;
  logic [CMP_W-1:0]   area, tidx_x;
  logic               wr_ok;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [RGBA_W-1:0]  ram_wdata, ram_rdata;
  logic [SX_W-1:0]    rx, ry;
  logic [DIM_W-1:0]   rw, rh;
  logic [ADDR_W-1:0]  rb;
  logic [CRD_W-1:0]   xc, yc;
  logic [ADDR_W+DIM_W:0] rsum;
  logic [DIM_W-1:0]   nw, nh;
  logic [2*DIM_W-1:0] parea;
  logic [RGBA_W-1:0]  box;
  logic [9:0]         csum [4];
  logic [DIM_W-1:0]   dw_s, dh_s;
  logic               lerp_start, lerp_done;
  logic [RGBA_W-1:0]  lerp_color;
  logic [RGBA_W-1:0]  res_color;
  logic               last_rd, lvl_end;
  logic               out_load;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // level 0 dimensions from the registers, clamped
  always_comb begin
    w0 = (wreg_r == '0) ? DIM_W'(1) : ((wreg_r > MAX_DIM) ? MAX_DIM : wreg_r);
    h0 = (hreg_r == '0) ? DIM_W'(1) : ((hreg_r > MAX_DIM) ? MAX_DIM : hreg_r);
    mx = (w0 > h0) ? w0 : h0;
    n_span = level_span(16'(mx));
    n_cap  = (n_span > lvl_t'(MAX_LEVELS)) ? lvl_t'(MAX_LEVELS) : n_span;
    area   = CMP_W'(w0 * h0);
    tidx_x = CMP_W'(f_tidx);
    wr_ok  = tidx_x < area;
  end

  // read address: clamp to the level edge and flatten
  always_comb begin
    if (state_r == ST_BRD) begin
      rx = SX_W'({bx_r, q_r[0]});
      ry = SX_W'({by_r, q_r[1]});
      rw = pw_r;
      rh = ph_r;
      rb = pb_r;
    end else begin
      rx = px_r[POS_W-1:FRAC_W] + SX_W'(q_r[0]);
      ry = py_r[POS_W-1:FRAC_W] + SX_W'(q_r[1]);
      rw = sw_r;
      rh = sh_r;
      rb = sb_r;
    end
    xc = (rx > SX_W'(rw - 1'b1)) ? CRD_W'(rw - 1'b1) : rx[CRD_W-1:0];
    yc = (ry > SX_W'(rh - 1'b1)) ? CRD_W'(rh - 1'b1) : ry[CRD_W-1:0];
    rsum = (ADDR_W+DIM_W+1)'(rb) + (ADDR_W+DIM_W+1)'(yc * rw)
         + (ADDR_W+DIM_W+1)'(xc);
    ram_raddr = rsum[ADDR_W-1:0];
    ram_re    = (state_r == ST_BRD) || (state_r == ST_SRD);
  end

  // next level geometry and the 2x2 box average
  always_comb begin
    nw    = ((pw_r >> 1) == '0) ? DIM_W'(1) : (pw_r >> 1);
    nh    = ((ph_r >> 1) == '0) ? DIM_W'(1) : (ph_r >> 1);
    parea = pw_r * ph_r;
    for (int c = 0; c < 4; c++) begin
      csum[c] = 10'(tex_r[0][8*c +: 8]) + 10'(tex_r[1][8*c +: 8])
              + 10'(tex_r[2][8*c +: 8]) + 10'(ram_rdata[8*c +: 8]);
      box[8*c +: 8] = csum[c][9:2];
    end
  end

  // texel memory write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dst_r;
    ram_wdata = box;
    if (in_fire && in_tuser == CMD_WRITE && wr_ok) begin
      ram_we    = 1'b1;
      ram_waddr = tidx_x[ADDR_W-1:0];
      ram_wdata = f_rgba;
    end else if (state_r == ST_BWR) begin
      ram_we = 1'b1;
    end
  end

  mts_ram #(
    .WIDTH (RGBA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lerp_start = (state_r == ST_SWT) && (cmd_r == CMD_BILINEAR);

  mts_lerp u_lerp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lerp_start),
    .tex_a  (tex_r[0]),
    .tex_b  (tex_r[1]),
    .tex_d  (tex_r[2]),
    .tex_e  (tex_r[3]),
    .frac_x (px_r[FRAC_W-1:0]),
    .frac_y (py_r[FRAC_W-1:0]),
    .done   (lerp_done),
    .color  (lerp_color)
  );

  // sampled level dimensions
  always_comb begin
    dw_s = lv0_r ? w0 : lw_r[lv_r];
    dh_s = lv0_r ? h0 : lh_r[lv_r];
  end

  always_comb begin
    case (cmd_r)
      CMD_NEAREST:  res_color = tex_r[0];
      CMD_BILINEAR: res_color = lerp_color;
      default:      res_color = '0;
    endcase
    last_rd = (cmd_r == CMD_BILINEAR) ? (q_r == 2'd3) : 1'b1;
    lvl_end = (bx_r == CRD_W'(cw_r - 1'b1)) && (by_r == CRD_W'(ch_r - 1'b1));
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      wreg_r        <= DIM_W'(1);
      hreg_r        <= DIM_W'(1);
      level_count_r <= lvl_t'(1);
      out_valid_r   <= 1'b0;
      rd_pend_r     <= 1'b0;
    end else begin
      rd_pend_r <= ram_re;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_BASE_WIDTH) wreg_r <= cfg_data;
        else hreg_r <= cfg_data;
        level_count_r <= lvl_t'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_tuser)
              CMD_BUILD: begin
                if (n_cap == lvl_t'(1)) begin
                  state_r       <= ST_DONE;
                  level_count_r <= lvl_t'(1);
                end else begin
                  state_r <= ST_BLV;
                end
              end
              CMD_NEAREST, CMD_BILINEAR: state_r <= ST_SPOS;
              default: state_r <= ST_DONE;
            endcase
          end
        end
        ST_BLV:  state_r <= ST_BRD;
        ST_BRD:  if (q_r == 2'd3) state_r <= ST_BWR;
        ST_BWR: begin
          if (lvl_end) begin
            if (lvl_t'(lvl_r) == n_r - lvl_t'(1)) begin
              state_r       <= ST_DONE;
              level_count_r <= n_r;
            end else begin
              state_r <= ST_BLV;
            end
          end else begin
            state_r <= ST_BRD;
          end
        end
        ST_SPOS: state_r <= ST_SRD;
        ST_SRD:  if (last_rd) state_r <= ST_SWT;
        ST_SWT:  state_r <= (cmd_r == CMD_BILINEAR) ? ST_LERP : ST_DONE;
        ST_LERP: if (lerp_done) state_r <= ST_DONE;
        ST_DONE: if (out_load) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rd_pend_r) tex_r[rd_slot_r] <= ram_rdata;
    rd_slot_r <= q_r;
    if (ram_re) q_r <= q_r + 2'd1;
    if (in_fire) begin
      cmd_r <= in_tuser;
      u_r   <= f_u;
      v_r   <= f_v;
      q_r   <= 2'd0;
      lv0_r <= !((f_lvl < level_count_r) && (f_lvl != '0));
      lv_r  <= (f_lvl < level_count_r) ? LIDX_W'(f_lvl) : '0;
      n_r   <= n_cap;
      pw_r  <= w0;
      ph_r  <= h0;
      pb_r  <= '0;
      lvl_r <= LIDX_W'(1);
    end
    // level setup
    if (state_r == ST_BLV) begin
      lw_r[lvl_r] <= nw;
      lh_r[lvl_r] <= nh;
      lb_r[lvl_r] <= ADDR_W'(pb_r + ADDR_W'(parea));
      cw_r  <= nw;
      ch_r  <= nh;
      dst_r <= ADDR_W'(pb_r + ADDR_W'(parea));
      bx_r  <= '0;
      by_r  <= '0;
    end
    // advance over the level
    if (state_r == ST_BWR) begin
      dst_r <= dst_r + 1'b1;
      if (bx_r == CRD_W'(cw_r - 1'b1)) begin
        bx_r <= '0;
        by_r <= by_r + 1'b1;
      end else begin
        bx_r <= bx_r + 1'b1;
      end
      // the finished level becomes the source of the next one
      if (lvl_end) begin
        pw_r  <= cw_r;
        ph_r  <= ch_r;
        pb_r  <= lb_r[lvl_r];
        lvl_r <= lvl_r + 1'b1;
      end
    end
    // sample positions
    if (state_r == ST_SPOS) begin
      sw_r <= dw_s;
      sh_r <= dh_s;
      sb_r <= lv0_r ? '0 : lb_r[lv_r];
      px_r <= POS_W'((dw_s - 1'b1) * u_r) + POS_W'(HALF_Q16);
      py_r <= POS_W'((dh_s - 1'b1) * v_r) + POS_W'(HALF_Q16);
    end
    if (out_load) begin
      out_data_r <= {4'b0, level_count_r, res_color};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // level count stays within the chain
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (level_count_r != '0) && (level_count_r <= lvl_t'(MAX_LEVELS)))
    else $error("level count out of range");

  // register write drops the chain
  a_cfg_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (level_count_r == lvl_t'(1)))
    else $error("mip chain kept after register write");

  // no texel write while a sample is reading
  a_no_wr_sample: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SPOS) || (state_r == ST_SRD) || (state_r == ST_LERP)) |-> !ram_we)
    else $error("texel write during sample");

  // a new result only leaves the done state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside done state");
`endif

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// mipmap texture sampler testbench
// Loads base texels, builds mip chains and samples them nearest and bilinear
// under random stalls on both streams; every result is checked against an
// in-bench predictor of the texel store and mip chain.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mts_pkg::*;

  localparam int LEVELS = 9;
  localparam int DIM_MAX = 256;
  localparam int DEPTH = 87381;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] color;
    logic [3:0]  levels;
  } sample_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [CMD_W-1:0] in_tuser = CMD_WRITE;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_BASE_WIDTH;
  logic [8:0] cfg_data = '0;

  // texture state mirrored by the predictor
  logic [31:0] texels [DEPTH];
  int unsigned lvl_w [LEVELS];
  int unsigned lvl_h [LEVELS];
  int unsigned lvl_base [LEVELS];
  int unsigned lvl_count;
  int unsigned reg_w, reg_h;

  sample_result_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;

  mipmap_texture_sampler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned clamp_dim(int unsigned d);
    if (d < 1) return 1;
    if (d > DIM_MAX) return DIM_MAX;
    return d;
  endfunction

  function automatic void refresh_base_level();
    lvl_w[0] = clamp_dim(reg_w);
    lvl_h[0] = clamp_dim(reg_h);
    lvl_base[0] = 0;
  endfunction

  function automatic logic [31:0] read_texel(int unsigned lv, longint x, longint y);
    if (x > lvl_w[lv] - 1) x = lvl_w[lv] - 1;
    if (x < 0) x = 0;
    if (y > lvl_h[lv] - 1) y = lvl_h[lv] - 1;
    if (y < 0) y = 0;
    return texels[lvl_base[lv] + y * lvl_w[lv] + x];
  endfunction

  function automatic void build_chain();
    int unsigned span, lg, n;
    logic [31:0] t0, t1, t2, t3, acc;
    logic [9:0] s;
    refresh_base_level();
    span = (lvl_w[0] > lvl_h[0]) ? lvl_w[0] : lvl_h[0];
    lg = 0;
    while ((span >> (lg + 1)) != 0) lg++;
    n = (lg + 1 > LEVELS) ? LEVELS : lg + 1;
    for (int k = 1; k < n; k++) begin
      lvl_w[k] = (lvl_w[k-1] >> 1) ? (lvl_w[k-1] >> 1) : 1;
      lvl_h[k] = (lvl_h[k-1] >> 1) ? (lvl_h[k-1] >> 1) : 1;
      lvl_base[k] = lvl_base[k-1] + lvl_w[k-1] * lvl_h[k-1];
    end
    for (int k = 1; k < n; k++) begin
      for (int y = 0; y < lvl_h[k]; y++) begin
        for (int x = 0; x < lvl_w[k]; x++) begin
          t0 = read_texel(k-1, 2*x, 2*y);
          t1 = read_texel(k-1, 2*x+1, 2*y);
          t2 = read_texel(k-1, 2*x, 2*y+1);
          t3 = read_texel(k-1, 2*x+1, 2*y+1);
          for (int c = 0; c < 32; c += 8) begin
            s = t0[c+:8] + t1[c+:8] + t2[c+:8] + t3[c+:8];
            acc[c+:8] = s[9:2];
          end
          texels[lvl_base[k] + y * lvl_w[k] + x] = acc;
        end
      end
    end
    lvl_count = n;
  endfunction

  function automatic logic [31:0] sample_level(int unsigned lv, longint unsigned u,
                                              longint unsigned v, bit bilinear);
    longint unsigned px, py, fx, fy, r1, r2, r, q;
    longint sx, sy;
    logic [31:0] a, b, d, e, acc;
    px = longint'(lvl_w[lv] - 1) * u + 32768;
    py = longint'(lvl_h[lv] - 1) * v + 32768;
    sx = px >> 16;
    sy = py >> 16;
    fx = px & 16'hFFFF;
    fy = py & 16'hFFFF;
    if (!bilinear) return read_texel(lv, sx, sy);
    a = read_texel(lv, sx, sy);
    b = read_texel(lv, sx + 1, sy);
    d = read_texel(lv, sx, sy + 1);
    e = read_texel(lv, sx + 1, sy + 1);
    for (int c = 0; c < 32; c += 8) begin
      r1 = a[c+:8] * (65536 - fx) + b[c+:8] * fx;
      r2 = d[c+:8] * (65536 - fx) + e[c+:8] * fx;
      r = r1 * (65536 - fy) + r2 * fy;
      q = (r + 64'h80000000) >> 32;
      if (q > 255) q = 255;
      acc[c+:8] = q[7:0];
    end
    return acc;
  endfunction

  function automatic sample_result_t predict(logic [1:0] cmd, logic [15:0] idx,
      logic [31:0] rgba, logic [16:0] u, logic [16:0] v, logic [3:0] lv);
    sample_result_t res;
    int unsigned l;
    res.color = '0;
    refresh_base_level();
    if (cmd == CMD_WRITE) begin
      if (idx < lvl_w[0] * lvl_h[0]) texels[idx] = rgba;
    end else if (cmd == CMD_BUILD) begin
      build_chain();
    end else begin
      l = (lv >= lvl_count) ? 0 : lv;
      res.color = sample_level(l, u, v, cmd == CMD_BILINEAR);
    end
    res.levels = lvl_count[3:0];
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_request(logic [1:0] cmd, logic [15:0] idx, logic [31:0] rgba,
                              logic [16:0] u, logic [16:0] v, logic [3:0] lv);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tdata = {2'b00, lv, v, u, rgba, idx};
    in_tuser = cmd;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(predict(cmd, idx, rgba, u, v, lv));
    sent++;
  endtask

  task automatic send_random_fields(logic [1:0] cmd);
    send_request(cmd, 16'($urandom), $urandom, 17'($urandom), 17'($urandom),
                 4'($urandom));
  endtask

  task automatic sample_random(logic [1:0] cmd);
    logic [16:0] u, v;
    u = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    v = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    send_request(cmd, 16'($urandom), $urandom, u, v,
                 ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, lvl_count)));
  endtask

  // wait for an idle block, then write one register
  task automatic write_reg(logic idx, logic [8:0] value);
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (20) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_BASE_WIDTH) reg_w = value;
    else reg_h = value;
    lvl_count = 1;
    refresh_base_level();
  endtask

  task automatic set_size_and_fill(logic [8:0] w, logic [8:0] h);
    write_reg(REG_BASE_WIDTH, w);
    write_reg(REG_BASE_HEIGHT, h);
    for (int i = 0; i < lvl_w[0] * lvl_h[0]; i++)
      send_request(CMD_WRITE, 16'(i), $urandom, 17'($urandom), 17'($urandom), 4'($urandom));
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 15);
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    sample_result_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_tvalid && out_tready) begin
        got.color = out_tdata[31:0];
        got.levels = out_tdata[35:32];
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected: %h", $time, got);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.color !== want.color) begin
            $display("%0t: color_rgba expected %h actual %h", $time, want.color, got.color);
            errors++;
          end
          if (got.levels !== want.levels) begin
            $display("%0t: levels_in_use expected %0d actual %0d", $time, want.levels,
                     got.levels);
            errors++;
          end
        end
      end
      if (idle_cycles > STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_extremes();
    // one texel, widest row, tallest column, both register clamps
    set_size_and_fill(9'd1, 9'd1);
    send_request(CMD_BUILD, '0, '0, '0, '0, '0);
    send_request(CMD_NEAREST, 16'hFFFF, '1, 17'd65536, 17'd65536, 4'd0);
    set_size_and_fill(9'd300, 9'd0);
    send_request(CMD_BUILD, '0, '0, '0, '0, '0);
    for (int l = 0; l < 9; l++) begin
      send_request(CMD_BILINEAR, '0, '0, 17'($urandom_range(0, 65536)), 17'd0, 4'(l));
      send_request(CMD_NEAREST, '0, '0, 17'd65536, 17'd1, 4'(l));
    end
    set_size_and_fill(9'd1, 9'd256);
    send_request(CMD_BUILD, '0, '0, '0, '0, '0);
    send_request(CMD_BILINEAR, '0, '0, 17'd0, 17'd65535, 4'd8);
    send_request(CMD_BILINEAR, '0, '0, 17'h1FFFF, 17'h1FFFF, 4'd15);
  endtask

  task automatic test_special_cases();
    set_size_and_fill(9'd5, 9'd3);
    // invalid level before a build, write beyond the base level
    send_request(CMD_NEAREST, '0, '0, 17'd32768, 17'd32768, 4'd2);
    send_request(CMD_WRITE, 16'd15, '1, '0, '0, '0);
    send_request(CMD_WRITE, 16'hFFFF, '1, '0, '0, '0);
    send_request(CMD_BUILD, '0, '0, '0, '0, '0);
    // base write after build keeps old mips
    send_request(CMD_WRITE, 16'd0, 32'hFFFF_FFFF, '0, '0, '0);
    send_request(CMD_BILINEAR, '0, '0, 17'd0, 17'd0, 4'd1);
    send_request(CMD_BILINEAR, '0, '0, 17'd0, 17'd0, 4'd0);
    // coordinate above one clamps at the edge
    send_request(CMD_BILINEAR, '0, '0, 17'h1FFFF, 17'd70000, 4'd0);
    // register write drops the chain
    write_reg(REG_BASE_WIDTH, 9'd5);
    send_request(CMD_NEAREST, '0, '0, 17'd40000, 17'd20000, 4'd1);
  endtask

  task automatic test_random_traffic(int target);
    int w, h, ops, pick;
    while (sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        w = $urandom_range(16, 32);
        h = $urandom_range(1, 2);
        if ($urandom_range(0, 1)) begin
          pick = w; w = h; h = pick;
        end
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      set_size_and_fill(9'(w), 9'(h));
      send_random_fields(CMD_BUILD);
      ops = $urandom_range(30, 60);
      for (int i = 0; i < ops; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 7) sample_random(CMD_NEAREST);
        else if (pick < 14) sample_random(CMD_BILINEAR);
        else if (pick < 18)
          send_request(CMD_WRITE, ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, w * h - 1)), $urandom, 17'($urandom),
                       17'($urandom), 4'($urandom));
        else send_random_fields(CMD_BUILD);
      end
    end
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) sample_random(CMD_BILINEAR);
  endtask

  initial begin
    int drain;
    reg_w = 1;
    reg_h = 1;
    lvl_count = 1;
    for (int k = 0; k < LEVELS; k++) begin
      lvl_w[k] = 0; lvl_h[k] = 0; lvl_base[k] = 0;
    end
    refresh_base_level();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_special_cases();
    test_output_backpressure();
    test_random_traffic(620);
    quiet = 1'b1;
    test_random_traffic(sent + 30);
    @(negedge clk);
    in_tvalid = 1'b0;
    drain = 0;
    while (expected_q.size() != 0 && drain < STALL_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (40) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/mts_pkg.sv
design/mts_ram.sv
design/mts_lerp.sv
design/mipmap_texture_sampler.sv
tb/sv/testbench.sv
